FILE: hw/rtl/btod_pkg.sv
`default_nettype none

package btod_pkg;

    // Item operation codes
    typedef enum logic [1:0] {
        OP_TICK  = 2'd0,
        OP_READ  = 2'd1,
        OP_WRITE = 2'd2,
        OP_NONE  = 2'd3
    } t_op;

    // Register positions along the chain
    localparam logic [1:0] REG_TENTHS  = 2'd0;
    localparam logic [1:0] REG_SECONDS = 2'd1;
    localparam logic [1:0] REG_MINUTES = 2'd2;
    localparam logic [1:0] REG_HOURS   = 2'd3;

    localparam int unsigned NUM_CELLS = 4;

    // Hours byte layout
    localparam logic [7:0] HOUR_WRITE_MASK = 8'h9f;
    localparam logic [7:0] PM_BIT          = 8'h80;
    localparam logic [4:0] HOUR_FIELD      = 5'h1f;
    localparam logic [4:0] HOUR_TWELVE     = 5'h12;
    localparam logic [4:0] HOUR_ELEVEN     = 5'h11;
    localparam logic [4:0] HOUR_TEN_BCD    = 5'h10;
    localparam logic [5:0] HOUR_TEN_BIN    = 6'd10;
    localparam logic [7:0] HOUR_RESET      = 8'h01;

    // Command broadcast to every cell for the accepted transaction
    typedef struct packed {
        logic       en;
        t_op        op;
        logic [1:0] idx;
        logic [7:0] data;
        logic       alarm_sel;
        logic       hold_active;
    } t_cmd;

    // Quotient by ten for values up to 255 (reciprocal multiply)
    function automatic logic [4:0] div10(input logic [7:0] v);
        logic [18:0] p;
        p = 19'(v) * 19'd205;
        return p[15:11];
    endfunction

    // Binary value below 100 to packed BCD
    function automatic logic [7:0] to_bcd(input logic [7:0] v);
        logic [4:0] q;
        logic [7:0] r;
        q = div10(v);
        r = v - 8'(8'(q) * 8'd10);
        return {q[3:0], r[3:0]};
    endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/btod_cell.sv
`default_nettype none

module btod_cell
    import btod_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic [1:0] i_pos,
    input  wire t_cmd       i_cmd,
    input  wire logic       i_carry,
    output logic            o_carry,
    output logic            o_match,
    output logic [7:0]      o_hold
);

    logic [7:0] r_time, n_time;
    logic [7:0] r_alarm, n_alarm;
    logic [7:0] r_hold, n_hold;

    logic [7:0] val;
    logic [4:0] q10;
    logic [7:0] rem10;
    logic [7:0] m60;
    logic [7:0] inc_sec;
    logic [7:0] inc_hour;
    logic [7:0] inc_value;
    logic       wrap;
    logic [4:0] hour;
    logic [5:0] hour_sum;
    logic [4:0] hour_next;
    logic       pm;
    logic [7:0] wdata;
    logic       wr_here;

    // Digit byte as binary plus one
    assign val   = 8'(8'(r_time[7:4]) * 8'd10) + 8'(r_time[3:0]) + 8'd1;
    assign q10   = div10(val);
    assign rem10 = val - 8'(8'(q10) * 8'd10);

    // Modulo sixty by compare and subtract
    always_comb begin
        priority if (val >= 8'd120) begin
            m60 = val - 8'd120;
        end else if (val >= 8'd60) begin
            m60 = val - 8'd60;
        end else begin
            m60 = val;
        end
    end
    assign inc_sec = to_bcd(m60);

    // 12-hour step with AM/PM flip on 11 -> 12
    always_comb begin
        hour     = r_time[4:0];
        hour_sum = 6'(hour) + 6'd1;
        pm       = r_time[7] ^ (hour == HOUR_ELEVEN);
        if (hour == HOUR_TWELVE) begin
            hour_next = 5'd1;
        end else if (hour_sum == HOUR_TEN_BIN) begin
            hour_next = HOUR_TEN_BCD;
        end else begin
            hour_next = hour_sum[4:0] & HOUR_FIELD;
        end
        inc_hour = {pm, 2'b00, hour_next};
    end

    // Advanced value and wrap per position
    always_comb begin
        unique case (i_pos)
            REG_TENTHS: begin
                inc_value = {4'h0, rem10[3:0]};
                wrap      = val >= 8'd10;
            end
            REG_SECONDS, REG_MINUTES: begin
                inc_value = inc_sec;
                wrap      = val >= 8'd60;
            end
            default: begin
                inc_value = inc_hour;
                wrap      = 1'b0;
            end
        endcase
    end
    assign o_carry = i_carry & wrap;

    // Write data, hours byte masked and 12 flips AM/PM on time writes
    always_comb begin
        wdata = i_cmd.data;
        if (i_pos == REG_HOURS) begin
            wdata = i_cmd.data & HOUR_WRITE_MASK;
            if (wdata[4:0] == HOUR_TWELVE && !i_cmd.alarm_sel) begin
                wdata = wdata ^ PM_BIT;
            end
        end
    end
    assign wr_here = i_cmd.en && i_cmd.op == OP_WRITE && i_cmd.idx == i_pos;

    // Next state of the cell
    always_comb begin
        n_time  = r_time;
        n_alarm = r_alarm;
        n_hold  = r_hold;
        if (wr_here && !i_cmd.alarm_sel) begin
            n_time = wdata;
        end else if (i_carry) begin
            n_time = inc_value;
        end
        if (wr_here && i_cmd.alarm_sel) begin
            n_alarm = wdata;
        end
        if (i_cmd.en && i_cmd.op == OP_READ && !i_cmd.hold_active) begin
            n_hold = r_time;
        end
    end

    assign o_match = n_time == n_alarm;
    assign o_hold  = n_hold;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_time  <= (i_pos == REG_HOURS) ? HOUR_RESET : 8'h00;
            r_alarm <= 8'h00;
            r_hold  <= 8'h00;
        end else begin
            r_time  <= n_time;
            r_alarm <= n_alarm;
            r_hold  <= n_hold;
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/bcd_time_of_day_clock_alarm_top.sv
`default_nettype none

// Channel   Direction  Handshake          Payload
// input     in         i_valid / o_stall  i_operation, i_reg_index, i_write_data, i_alarm_select
// result    out        o_valid / i_stall  o_read_data, o_alarm_hit
//
// One transaction per cycle unless stalled: the four digit cells update in the
// accept cycle, the tick carry ripples through the cell chain within that cycle.
// The result is registered in the output register, or in the skid register
// when the output register is full and not taken. A skid register holds one more
// result, so input is stalled only when both output register and skid register are full.
// Synchronous active-low reset: time 01:00:00.0, clock stopped, no hold.

module bcd_time_of_day_clock_alarm_top
    import btod_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    output logic            o_stall,
    input  wire logic [1:0] i_operation,
    input  wire logic [1:0] i_reg_index,
    input  wire logic [7:0] i_write_data,
    input  wire logic       i_alarm_select,
    output logic            o_valid,
    input  wire logic       i_stall,
    output logic [7:0]      o_read_data,
    output logic            o_alarm_hit
);

    logic        accept;
    t_cmd        cmd;
    logic        r_hold_active, n_hold_active;
    logic        r_stopped, n_stopped;
    logic [NUM_CELLS:0]   carry;
    logic [NUM_CELLS-1:0] match;
    logic [7:0]  hold [NUM_CELLS];
    logic [7:0]  res_rd;
    logic        res_hit;

    logic        r_out_valid;
    logic [7:0]  r_out_rd;
    logic        r_out_hit;
    logic        r_skid_valid;
    logic [7:0]  r_skid_rd;
    logic        r_skid_hit;
    logic        pop;

    assign o_stall = r_skid_valid;
    assign accept  = i_valid && !r_skid_valid;

    // Command broadcast along the chain
    always_comb begin
        cmd.en          = accept;
        cmd.op          = t_op'(i_operation);
        cmd.idx         = i_reg_index;
        cmd.data        = i_write_data;
        cmd.alarm_sel   = i_alarm_select;
        cmd.hold_active = r_hold_active;
    end

    assign carry[0] = accept && cmd.op == OP_TICK && !r_stopped;

    // Digit cell chain: tenths, seconds, minutes, hours
    for (genvar g = 0; g < NUM_CELLS; g++) begin : g_cell
        btod_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_pos   (2'(g)),
            .i_cmd   (cmd),
            .i_carry (carry[g]),
            .o_carry (carry[g+1]),
            .o_match (match[g]),
            .o_hold  (hold[g])
        );
    end

    // Hold and run/stop control
    always_comb begin
        n_hold_active = r_hold_active;
        n_stopped     = r_stopped;
        if (accept && cmd.op == OP_READ) begin
            if (cmd.idx == REG_TENTHS) n_hold_active = 1'b0;
            if (cmd.idx == REG_HOURS)  n_hold_active = 1'b1;
        end
        if (accept && cmd.op == OP_WRITE && !cmd.alarm_sel) begin
            if (cmd.idx == REG_TENTHS) n_stopped = 1'b0;
            if (cmd.idx == REG_HOURS)  n_stopped = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold_active <= 1'b0;
            r_stopped     <= 1'b1;
        end else begin
            r_hold_active <= n_hold_active;
            r_stopped     <= n_stopped;
        end
    end

    // Result fields
    assign res_rd  = (cmd.op == OP_READ) ? hold[cmd.idx] : 8'h00;
    assign res_hit = (cmd.op == OP_TICK || cmd.op == OP_WRITE) && !n_stopped && (&match);

    // Output register with skid stage
    assign pop = r_out_valid && !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (pop) begin
                r_skid_valid <= 1'b0;
            end
        end else if (accept) begin
            if (r_out_valid && !pop) begin
                r_skid_valid <= 1'b1;
            end
            r_out_valid <= 1'b1;
        end else if (pop) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (pop) begin
                r_out_rd  <= r_skid_rd;
                r_out_hit <= r_skid_hit;
            end
        end else if (accept) begin
            if (r_out_valid && !pop) begin
                r_skid_rd  <= res_rd;
                r_skid_hit <= res_hit;
            end else begin
                r_out_rd  <= res_rd;
                r_out_hit <= res_hit;
            end
        end
    end

    assign o_valid     = r_out_valid;
    assign o_read_data = r_out_rd;
    assign o_alarm_hit = r_out_hit;

endmodule

`default_nettype wire

FILE: tb/sv/bcd_time_of_day_clock_alarm_top_test.sv
module bcd_time_of_day_clock_alarm_top_test;
    import btod_pkg::*;

    localparam int unsigned RANDOM_ITEMS   = 1200;
    localparam int unsigned LONG_HOLD      = 300;
    localparam int unsigned WATCHDOG_LIMIT = 5000;
    localparam int unsigned SETTLE_CYCLES  = 8;
    localparam int unsigned MAX_REPORTS    = 10;

    typedef bit [3:0][7:0] tod_digits_t;

    typedef struct packed {
        bit [7:0] read_data;
        bit       alarm_hit;
    } tod_reply_t;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_valid;
    logic       o_stall;
    logic [1:0] i_operation;
    logic [1:0] i_reg_index;
    logic [7:0] i_write_data;
    logic       i_alarm_select;
    logic       o_valid;
    logic       i_stall;
    logic [7:0] o_read_data;
    logic       o_alarm_hit;

    // Predicted clock state
    tod_digits_t tod_now;
    tod_digits_t tod_alarm;
    tod_digits_t tod_frozen;
    bit          frozen_on;
    bit          tod_halted;

    tod_reply_t  replies_due[$];
    int unsigned items_sent;
    int unsigned mismatches;
    int unsigned idle_cycles;
    bit          no_idle;
    bit          long_hold_req;
    bit          long_hold_begun;

    bcd_time_of_day_clock_alarm_top dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_operation    (i_operation),
        .i_reg_index    (i_reg_index),
        .i_write_data   (i_write_data),
        .i_alarm_select (i_alarm_select),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_read_data    (o_read_data),
        .o_alarm_hit    (o_alarm_hit)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // ---------------------------------------------------------------
    // Clock predictor
    // ---------------------------------------------------------------

    // Digit pair read as 10*high + low, whatever the nibbles hold
    function automatic int unsigned digit_sum(bit [7:0] b);
        return 10 * b[7:4] + b[3:0];
    endfunction

    function automatic bit [7:0] pack_bcd(int unsigned v);
        return 8'(((v / 10) << 4) + (v % 10));
    endfunction

    // One tenth-second step with ripple carry
    function automatic tod_digits_t tick_digits(tod_digits_t d);
        int unsigned v;
        int unsigned hr;
        bit [7:0]    pm;
        v = digit_sum(d[REG_TENTHS]) + 1;
        d[REG_TENTHS] = pack_bcd(v % 10);
        if (v < 10) return d;
        v = digit_sum(d[REG_SECONDS]) + 1;
        d[REG_SECONDS] = pack_bcd(v % 60);
        if (v < 60) return d;
        v = digit_sum(d[REG_MINUTES]) + 1;
        d[REG_MINUTES] = pack_bcd(v % 60);
        if (v < 60) return d;
        pm = d[REG_HOURS] & PM_BIT;
        hr = 32'(d[REG_HOURS][4:0]);
        if (hr == 32'(HOUR_ELEVEN)) pm = pm ^ PM_BIT;
        if (hr == 32'(HOUR_TWELVE)) begin
            hr = 1;
        end else begin
            hr = hr + 1;
            if (hr == 32'(HOUR_TEN_BIN)) hr = 32'(HOUR_TEN_BCD);
        end
        d[REG_HOURS] = {3'b000, hr[4:0]} | pm;
        return d;
    endfunction

    // Apply one accepted transaction and queue the reply it must produce
    function automatic void apply_clock_access(t_op op, bit [1:0] idx, bit [7:0] data,
                                               bit asel);
        tod_reply_t r;
        bit [7:0]   wdata;
        r = '0;
        case (op)
            OP_TICK: begin
                if (!tod_halted) begin
                    tod_now = tick_digits(tod_now);
                    r.alarm_hit = (tod_now == tod_alarm);
                end
            end
            OP_READ: begin
                if (!frozen_on) tod_frozen = tod_now;
                if (idx == REG_TENTHS) frozen_on = 1'b0;
                if (idx == REG_HOURS) frozen_on = 1'b1;
                r.read_data = tod_frozen[idx];
            end
            OP_WRITE: begin
                wdata = data;
                if (idx == REG_HOURS) begin
                    wdata = wdata & HOUR_WRITE_MASK;
                    if (wdata[4:0] == HOUR_TWELVE && !asel) wdata = wdata ^ PM_BIT;
                end
                if (asel) begin
                    tod_alarm[idx] = wdata;
                end else begin
                    if (idx == REG_TENTHS) tod_halted = 1'b0;
                    if (idx == REG_HOURS) tod_halted = 1'b1;
                    tod_now[idx] = wdata;
                end
                r.alarm_hit = !tod_halted && (tod_now == tod_alarm);
            end
            default: ;
        endcase
        replies_due.push_back(r);
    endfunction

    // ---------------------------------------------------------------
    // Idle gaps: mostly none or short, a few long
    // ---------------------------------------------------------------
    function automatic int unsigned pick_gap();
        int unsigned r;
        if (no_idle) return 0;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // ---------------------------------------------------------------
    // Sender
    // ---------------------------------------------------------------

    // Offer one transaction and wait for the block to take it
    task automatic send_item(t_op op, bit [1:0] idx, bit [7:0] data, bit asel);
        int unsigned gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid        <= 1'b1;
        i_operation    <= op;
        i_reg_index    <= idx;
        i_write_data   <= data;
        i_alarm_select <= asel;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        apply_clock_access(op, idx, data, asel);
        items_sent++;
    endtask

    task automatic send_noise();
        send_item(t_op'(2'($urandom_range(0, 3))), 2'($urandom_range(0, 3)),
                  8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
    endtask

    // Stop offering and wait until every reply is back
    task automatic wait_for_replies();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (replies_due.size() != 0);
    endtask

    // ---------------------------------------------------------------
    // Receiver stall pattern
    // ---------------------------------------------------------------
    initial begin
        int unsigned stall_len;
        int unsigned run_len;
        i_stall = 1'b0;
        @(posedge i_clk);
        forever begin
            if (long_hold_req) begin
                long_hold_req   = 1'b0;
                long_hold_begun = 1'b1;
                stall_len       = LONG_HOLD;
                run_len         = 1;
            end else begin
                stall_len = pick_gap();
                if (no_idle) run_len = 50;
                else if ($urandom_range(0, 9) == 0) run_len = $urandom_range(20, 60);
                else run_len = $urandom_range(1, 8);
            end
            if (stall_len > 0) begin
                i_stall <= 1'b1;
                repeat (stall_len) @(posedge i_clk);
            end
            i_stall <= 1'b0;
            repeat (run_len) @(posedge i_clk);
        end
    end

    // ---------------------------------------------------------------
    // Reply checker
    // ---------------------------------------------------------------
    always @(posedge i_clk) begin
        tod_reply_t want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (replies_due.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("unexpected reply: read_data=%h alarm_hit=%b",
                             o_read_data, o_alarm_hit);
            end else begin
                want = replies_due.pop_front();
                if (o_read_data !== want.read_data || o_alarm_hit !== want.alarm_hit) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display({"reply mismatch: expected read_data=%h alarm_hit=%b,",
                                  " got read_data=%h alarm_hit=%b"},
                                 want.read_data, want.alarm_hit, o_read_data, o_alarm_hit);
                end
            end
        end
    end

    // Watchdog: cycles with no transaction on either side
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no transaction for %0d cycles", idle_cycles);
            $display("Regression FAIL");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // ---------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------

    // Stopped clock ignores ticks; reads freeze on hours, release on tenths
    task automatic test_reset_state();
        send_item(OP_TICK, REG_TENTHS, 8'h00, 1'b0);
        send_item(OP_READ, REG_HOURS, 8'h00, 1'b0);
        send_item(OP_READ, REG_MINUTES, 8'h00, 1'b0);
        send_item(OP_READ, REG_SECONDS, 8'h00, 1'b0);
        send_item(OP_READ, REG_TENTHS, 8'h00, 1'b0);
    endtask

    // Hours masking, PM flip on time writes of twelve, unused opcode
    task automatic test_hour_writes();
        send_item(OP_WRITE, REG_HOURS, 8'hff, 1'b1);
        send_item(OP_WRITE, REG_HOURS, 8'(HOUR_TWELVE), 1'b1);
        send_item(OP_WRITE, REG_HOURS, 8'(HOUR_TWELVE), 1'b0);
        send_item(OP_WRITE, REG_HOURS, 8'hff, 1'b0);
        send_item(OP_NONE, REG_HOURS, 8'hff, 1'b1);
    endtask

    // 11:59:59.9 AM rolls into 12 PM and meets the alarm
    task automatic test_rollover_alarm();
        send_item(OP_WRITE, REG_HOURS, 8'(HOUR_ELEVEN), 1'b0);
        send_item(OP_WRITE, REG_MINUTES, 8'h59, 1'b0);
        send_item(OP_WRITE, REG_SECONDS, 8'h59, 1'b0);
        send_item(OP_WRITE, REG_TENTHS, 8'h00, 1'b1);
        send_item(OP_WRITE, REG_SECONDS, 8'h00, 1'b1);
        send_item(OP_WRITE, REG_MINUTES, 8'h00, 1'b1);
        send_item(OP_WRITE, REG_HOURS, PM_BIT | 8'(HOUR_TWELVE), 1'b1);
        send_item(OP_WRITE, REG_TENTHS, 8'h09, 1'b0);
        send_item(OP_TICK, REG_HOURS, 8'h00, 1'b0);
    endtask

    // Non-BCD digits carry through every stage; out-of-range hour wraps
    task automatic test_odd_digits();
        send_item(OP_WRITE, REG_HOURS, 8'h1f, 1'b0);
        send_item(OP_WRITE, REG_MINUTES, 8'h59, 1'b0);
        send_item(OP_WRITE, REG_SECONDS, 8'h59, 1'b0);
        send_item(OP_WRITE, REG_TENTHS, 8'hff, 1'b0);
        send_item(OP_TICK, REG_TENTHS, 8'hff, 1'b1);
    endtask

    // Receiver holds off while the sender keeps pushing
    task automatic test_back_pressure();
        no_idle         = 1'b1;
        long_hold_begun = 1'b0;
        long_hold_req   = 1'b1;
        while (!long_hold_begun) send_noise();
        repeat (20) send_item(OP_TICK, REG_TENTHS, 8'h00, 1'b0);
        no_idle = 1'b0;
    endtask

    // Sender pauses until the block has answered everything
    task automatic test_drain_pause();
        send_item(OP_WRITE, REG_TENTHS, 8'h00, 1'b0);
        repeat (5) send_item(OP_TICK, REG_TENTHS, 8'h00, 1'b0);
        wait_for_replies();
        repeat (5) send_item(OP_TICK, REG_TENTHS, 8'h00, 1'b0);
    endtask

    // Set a time near a carry boundary, start it, then tick through
    task automatic run_near_rollover();
        bit [7:0] hr;
        case ($urandom_range(0, 5))
            0: hr = 8'(HOUR_ELEVEN);
            1: hr = 8'(HOUR_TWELVE);
            2: hr = 8'h09;
            3: hr = 8'($urandom_range(0, 255));
            default: hr = pack_bcd($urandom_range(1, 12));
        endcase
        if ($urandom_range(0, 1)) hr = hr | PM_BIT;
        send_item(OP_WRITE, REG_HOURS, hr, 1'b0);
        send_item(OP_WRITE, REG_MINUTES,
                  $urandom_range(0, 2) ? 8'h59 : 8'($urandom_range(0, 255)), 1'b0);
        send_item(OP_WRITE, REG_SECONDS,
                  $urandom_range(0, 2) ? 8'h59 : 8'($urandom_range(0, 255)), 1'b0);
        send_item(OP_WRITE, REG_TENTHS, pack_bcd($urandom_range(0, 9)), 1'b0);
        repeat ($urandom_range(1, 25)) send_item(OP_TICK, 2'($urandom_range(0, 3)),
                                                 8'($urandom_range(0, 255)), 1'b0);
    endtask

    // Program the alarm a few ticks ahead and run into it
    task automatic run_alarm_chase();
        tod_digits_t target;
        int unsigned ahead;
        if (tod_halted) send_item(OP_WRITE, REG_TENTHS, pack_bcd($urandom_range(0, 9)), 1'b0);
        ahead  = $urandom_range(1, 6);
        target = tod_now;
        repeat (ahead) target = tick_digits(target);
        send_item(OP_WRITE, REG_TENTHS, target[REG_TENTHS], 1'b1);
        send_item(OP_WRITE, REG_SECONDS, target[REG_SECONDS], 1'b1);
        send_item(OP_WRITE, REG_MINUTES, target[REG_MINUTES], 1'b1);
        send_item(OP_WRITE, REG_HOURS, target[REG_HOURS], 1'b1);
        repeat (ahead) send_item(OP_TICK, REG_TENTHS, 8'h00, 1'b0);
    endtask

    // Hours-first read of the frozen time with ticks in between
    task automatic run_read_sequence();
        send_item(OP_READ, REG_HOURS, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        repeat ($urandom_range(0, 3)) send_item(OP_TICK, REG_TENTHS, 8'h00, 1'b0);
        send_item(OP_READ, REG_MINUTES, 8'h00, 1'b0);
        send_item(OP_READ, REG_SECONDS, 8'h00, 1'b0);
        if ($urandom_range(0, 1)) send_item(OP_TICK, REG_TENTHS, 8'h00, 1'b0);
        send_item(OP_READ, REG_TENTHS, 8'h00, 1'b0);
        if ($urandom_range(0, 1))
            send_item(OP_READ, 2'($urandom_range(0, 3)), 8'h00, 1'b0);
    endtask

    task automatic test_random_traffic();
        int unsigned stop_at;
        stop_at = items_sent + RANDOM_ITEMS;
        while (items_sent < stop_at) begin
            no_idle = ($urandom_range(0, 9) == 0);
            case ($urandom_range(0, 9))
                0, 1: run_near_rollover();
                2, 3: run_alarm_chase();
                4, 5: run_read_sequence();
                6, 7: repeat ($urandom_range(1, 20))
                          send_item(OP_TICK, 2'($urandom_range(0, 3)),
                                    8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
                default: repeat ($urandom_range(1, 6)) send_noise();
            endcase
            if ($urandom_range(0, 19) == 0) wait_for_replies();
        end
        no_idle = 1'b0;
    endtask

    // ---------------------------------------------------------------
    // Sequence
    // ---------------------------------------------------------------
    initial begin
        i_rst_n         = 1'b0;
        i_valid         = 1'b0;
        i_operation     = OP_TICK;
        i_reg_index     = REG_TENTHS;
        i_write_data    = 8'h00;
        i_alarm_select  = 1'b0;
        tod_now         = '0;
        tod_now[REG_HOURS] = HOUR_RESET;
        tod_alarm       = '0;
        tod_frozen      = '0;
        frozen_on       = 1'b0;
        tod_halted      = 1'b1;
        items_sent      = 0;
        mismatches      = 0;
        idle_cycles     = 0;
        no_idle         = 1'b0;
        long_hold_req   = 1'b0;
        long_hold_begun = 1'b0;

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_state();
        test_hour_writes();
        test_rollover_alarm();
        test_odd_digits();
        test_back_pressure();
        test_drain_pause();
        test_random_traffic();
        test_back_pressure();

        wait_for_replies();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("Regression PASS");
        end else begin
            $display("%0d reply mismatches", mismatches);
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

FILE: filelist.f
hw/rtl/btod_pkg.sv
hw/rtl/btod_cell.sv
hw/rtl/bcd_time_of_day_clock_alarm_top.sv
tb/sv/bcd_time_of_day_clock_alarm_top_test.sv
